[rtl/core/rsp_pkg.sv]
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types, codes and the multiply micro-program of the ray/segment pick.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WIDE_W    = 160;
    localparam int DOT_W     = 72;
    localparam int MPL_W     = 80;
    localparam int Q_LONG    = 31;
    localparam int Q_SHORT   = FRAC_BITS + 1;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [DOT_W-1:0]  dot_t;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_DIR_X    = 3'd3;
    localparam logic [2:0] CFG_DIR_Y    = 3'd4;
    localparam logic [2:0] CFG_DIR_Z    = 3'd5;
    localparam logic [2:0] CFG_TOL      = 3'd6;

    // operand sources
    localparam logic [3:0] SRC_DIR = 4'd0;
    localparam logic [3:0] SRC_U   = 4'd1;
    localparam logic [3:0] SRC_W   = 4'd2;
    localparam logic [3:0] SRC_DV  = 4'd3;
    localparam logic [3:0] SRC_A   = 4'd4;
    localparam logic [3:0] SRC_B   = 4'd5;
    localparam logic [3:0] SRC_C   = 4'd6;
    localparam logic [3:0] SRC_D   = 4'd7;
    localparam logic [3:0] SRC_E   = 4'd8;
    localparam logic [3:0] SRC_ST  = 4'd9;
    localparam logic [3:0] SRC_RT  = 4'd10;
    localparam logic [3:0] SRC_TOL = 4'd11;

    // what happens with the accumulator after a pass
    localparam logic [3:0] STO_NONE = 4'd0;
    localparam logic [3:0] STO_A    = 4'd1;
    localparam logic [3:0] STO_C    = 4'd2;
    localparam logic [3:0] STO_D    = 4'd3;
    localparam logic [3:0] STO_E    = 4'd4;
    localparam logic [3:0] STO_B    = 4'd5;
    localparam logic [3:0] STO_TSQ  = 4'd6;
    localparam logic [3:0] STO_DEN  = 4'd7;
    localparam logic [3:0] STO_NUM  = 4'd8;
    localparam logic [3:0] STO_N    = 4'd9;
    localparam logic [3:0] STO_RX   = 4'd10;
    localparam logic [3:0] STO_PX   = 4'd11;
    localparam logic [3:0] STO_DSQ  = 4'd12;

    // program entry points
    localparam logic [4:0] PC_START  = 5'd0;
    localparam logic [4:0] PC_DEN    = 5'd16;
    localparam logic [4:0] PC_N      = 5'd20;
    localparam logic [4:0] PC_POINTS = 5'd21;

    typedef struct packed {
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic [1:0] axis;
        logic       clr;
        logic       sub;
        logic [3:0] sto;
    } uop_t;

    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } mac_ctl_t;

    typedef struct packed {
        logic start;
        logic long_q;
    } div_ctl_t;

    function automatic uop_t mk(input logic [3:0] a, input logic [3:0] b,
                                input logic [1:0] ax, input logic clr,
                                input logic sub, input logic [3:0] sto);
        uop_t u;
        u.src_a = a;
        u.src_b = b;
        u.axis  = ax;
        u.clr   = clr;
        u.sub   = sub;
        u.sto   = sto;
        return u;
    endfunction

    function automatic uop_t uop_rom(input logic [4:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:  u = mk(SRC_DIR, SRC_DIR, 2'd0, 1'b1, 1'b0, STO_NONE);
            5'd1:  u = mk(SRC_DIR, SRC_DIR, 2'd1, 1'b0, 1'b0, STO_NONE);
            5'd2:  u = mk(SRC_DIR, SRC_DIR, 2'd2, 1'b0, 1'b0, STO_A);
            5'd3:  u = mk(SRC_U,   SRC_U,   2'd0, 1'b1, 1'b0, STO_NONE);
            5'd4:  u = mk(SRC_U,   SRC_U,   2'd1, 1'b0, 1'b0, STO_NONE);
            5'd5:  u = mk(SRC_U,   SRC_U,   2'd2, 1'b0, 1'b0, STO_C);
            5'd6:  u = mk(SRC_DIR, SRC_W,   2'd0, 1'b1, 1'b0, STO_NONE);
            5'd7:  u = mk(SRC_DIR, SRC_W,   2'd1, 1'b0, 1'b0, STO_NONE);
            5'd8:  u = mk(SRC_DIR, SRC_W,   2'd2, 1'b0, 1'b0, STO_D);
            5'd9:  u = mk(SRC_U,   SRC_W,   2'd0, 1'b1, 1'b0, STO_NONE);
            5'd10: u = mk(SRC_U,   SRC_W,   2'd1, 1'b0, 1'b0, STO_NONE);
            5'd11: u = mk(SRC_U,   SRC_W,   2'd2, 1'b0, 1'b0, STO_E);
            5'd12: u = mk(SRC_DIR, SRC_U,   2'd0, 1'b1, 1'b0, STO_NONE);
            5'd13: u = mk(SRC_DIR, SRC_U,   2'd1, 1'b0, 1'b0, STO_NONE);
            5'd14: u = mk(SRC_DIR, SRC_U,   2'd2, 1'b0, 1'b0, STO_B);
            5'd15: u = mk(SRC_TOL, SRC_TOL, 2'd0, 1'b1, 1'b0, STO_TSQ);
            5'd16: u = mk(SRC_A,   SRC_C,   2'd0, 1'b1, 1'b0, STO_NONE);
            5'd17: u = mk(SRC_B,   SRC_B,   2'd0, 1'b0, 1'b1, STO_DEN);
            5'd18: u = mk(SRC_A,   SRC_E,   2'd0, 1'b1, 1'b0, STO_NONE);
            5'd19: u = mk(SRC_B,   SRC_D,   2'd0, 1'b0, 1'b1, STO_NUM);
            5'd20: u = mk(SRC_B,   SRC_ST,  2'd0, 1'b1, 1'b0, STO_N);
            5'd21: u = mk(SRC_DIR, SRC_RT,  2'd0, 1'b1, 1'b0, STO_RX);
            5'd22: u = mk(SRC_U,   SRC_ST,  2'd0, 1'b1, 1'b0, STO_PX);
            5'd23: u = mk(SRC_DIR, SRC_RT,  2'd1, 1'b1, 1'b0, STO_RX);
            5'd24: u = mk(SRC_U,   SRC_ST,  2'd1, 1'b1, 1'b0, STO_PX);
            5'd25: u = mk(SRC_DIR, SRC_RT,  2'd2, 1'b1, 1'b0, STO_RX);
            5'd26: u = mk(SRC_U,   SRC_ST,  2'd2, 1'b1, 1'b0, STO_PX);
            5'd27: u = mk(SRC_DV,  SRC_DV,  2'd0, 1'b1, 1'b0, STO_NONE);
            5'd28: u = mk(SRC_DV,  SRC_DV,  2'd1, 1'b0, 1'b0, STO_NONE);
            5'd29: u = mk(SRC_DV,  SRC_DV,  2'd2, 1'b0, 1'b0, STO_DSQ);
            default: u = mk(SRC_A, SRC_A, 2'd0, 1'b1, 1'b0, STO_NONE);
        endcase
        return u;
    endfunction

endpackage

[rtl/core/rsp_mac.sv]
// ----------------------------------------------------------------------------
// rsp_mac
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rsp_mac (
    input  logic            clk,
    input  logic            rst_n,
    input  rsp_pkg::mac_ctl_t ctl,
    input  rsp_pkg::wide_t  op_a,
    input  rsp_pkg::wide_t  op_b,
    output rsp_pkg::wide_t  acc,
    output logic            done
);
    import rsp_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                neg_reg, neg_next;
    logic [WIDE_W-1:0]   mcand_reg, mcand_next;
    logic [MPL_W-1:0]    mplier_reg, mplier_next;
    logic [WIDE_W-1:0]   prod_reg, prod_next;
    wide_t               acc_reg, acc_next;
    wide_t               mag_a, mag_b;

    assign mag_a = op_a[WIDE_W-1] ? -op_a : op_a;
    assign mag_b = op_b[WIDE_W-1] ? -op_b : op_b;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        neg_next    = neg_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        if (ctl.start)
        begin
            busy_next   = 1'b1;
            neg_next    = op_a[WIDE_W-1] ^ op_b[WIDE_W-1] ^ ctl.sub;
            mcand_next  = mag_a;
            mplier_next = mag_b[MPL_W-1:0];
            prod_next   = '0;
            if (ctl.clr)
            begin
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (mplier_reg != '0)
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
            else
            begin
                acc_next  = neg_reg ? acc_reg - wide_t'(prod_reg) : acc_reg + wide_t'(prod_reg);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

[rtl/core/rsp_div.sv]
// ----------------------------------------------------------------------------
// rsp_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module rsp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rsp_pkg::div_ctl_t ctl,
    input  rsp_pkg::wide_t    num,
    input  rsp_pkg::wide_t    den,
    output logic [30:0]       q,
    output logic              done
);
    import rsp_pkg::*;

    logic              busy_reg, busy_next;
    logic              chk_reg, chk_next;
    logic              done_reg, done_next;
    logic              long_reg, long_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [WIDE_W-1:0] dd_reg, dd_next;
    logic [30:0]       q_reg, q_next;
    logic [WIDE_W-1:0] dd_half;

    assign dd_half = dd_reg >> 1;

    always_comb
    begin
        busy_next = busy_reg;
        chk_next  = chk_reg;
        done_next = 1'b0;
        long_next = long_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dd_next   = dd_reg;
        q_next    = q_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            chk_next  = 1'b1;
            long_next = ctl.long_q;
            rem_next  = num;
            dd_next   = ctl.long_q ? (den << Q_LONG) : (den << Q_SHORT);
            cnt_next  = ctl.long_q ? 5'(Q_LONG) : 5'(Q_SHORT);
            q_next    = '0;
        end
        else if (busy_reg && chk_reg)
        begin
            chk_next = 1'b0;
            if (rem_reg >= dd_reg)
            begin
                q_next    = long_reg ? {31{1'b1}} : 31'((1 << Q_SHORT) - 1);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            dd_next = dd_half;
            if (rem_reg >= dd_half)
            begin
                rem_next = rem_reg - dd_half;
                q_next   = {q_reg[29:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[29:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            chk_reg  <= chk_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        long_reg <= long_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dd_reg   <= dd_next;
        q_reg    <= q_next;
    end

    assign q    = q_reg;
    assign done = done_reg;

endmodule

[rtl/core/ray_segment_pick_top.sv]
// ----------------------------------------------------------------------------
// ray_segment_pick_top
// Closest points between a configured ray and a stream of segments, with a
// running nearest hit per pick.
// ----------------------------------------------------------------------------
//
// channel | direction | handshake            | word
// --------+-----------+----------------------+--------------------------------
// cfg     | in        | cfg_we               | cfg_index, cfg_data
// in      | in        | in_valid / in_stall  | segment start, end, last
// out     | out       | out_valid / out_stall| hit, params, point, best fields
//
// One word at a time. A word runs up to 30 passes of a bit-serial multiply-
// accumulate unit and at most two runs of a restoring divider.
// in_stall is high from acceptance until the result is written to the output
// register; a waiting result holds the final step, and with it the next word.
// Reset restores the configuration defaults and clears the pick state.
// ----------------------------------------------------------------------------
module ray_segment_pick_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic               new_best,
    output logic [15:0]        segment_number,
    output logic [30:0]        ray_param,
    output logic [16:0]        segment_param,
    output logic [62:0]        distance_sq,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic               best_found,
    output logic [15:0]        best_number,
    output logic               final_res
);
    import rsp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_CLAMP = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // sequencer
    logic [2:0] state_reg, state_next;
    logic       go_reg, go_next;
    logic [4:0] pc_reg, pc_next;
    logic [4:0] ret_reg, ret_next;
    logic       div_rt_reg, div_rt_next;

    // configuration
    logic signed [31:0] org_reg [0:2];
    logic signed [31:0] dir_reg [0:2];
    logic [30:0]        tol_reg;

    // per-word operands
    logic signed [31:0] s_reg [0:2];
    logic signed [32:0] u_reg [0:2];
    logic signed [32:0] w_reg [0:2];
    logic               last_reg;

    // intermediates
    dot_t               a_reg, a_next, b_reg, b_next, c_reg, c_next;
    dot_t               d_reg, d_next, e_reg, e_next;
    wide_t              cn_reg, cn_next, cd_reg, cd_next;
    logic [30:0]        rt_reg, rt_next;
    logic [16:0]        st_reg, st_next;
    logic [61:0]        tsq_reg, tsq_next;
    logic signed [49:0] rtmp_reg, rtmp_next;
    logic signed [35:0] px_reg [0:2];
    logic signed [35:0] px_next [0:2];
    logic signed [50:0] dv_reg [0:2];
    logic signed [50:0] dv_next [0:2];
    logic [62:0]        dist_reg, dist_next;

    // pick state
    logic [15:0] seg_reg, seg_next;
    logic [30:0] best_rt_reg, best_rt_next;
    logic [15:0] best_idx_reg, best_idx_next;
    logic        any_reg, any_next;

    // output word
    logic        out_valid_reg, out_valid_next;
    logic        out_load;
    logic        hit_reg, hit_next, newb_reg, newb_next;
    logic [15:0] segn_reg;
    logic [30:0] rtp_reg;
    logic [16:0] stp_reg;
    logic [62:0] dsq_reg;
    logic signed [31:0] pt_reg [0:2];
    logic        bf_reg;
    logic [15:0] bn_reg;
    logic        fin_reg;

    logic        in_take;
    uop_t        uop;
    mac_ctl_t    mac_ctl;
    div_ctl_t    div_ctl;
    wide_t       op_a, op_b, mac_acc, n_val, shifted;
    logic        mac_done, div_done;
    logic [30:0] div_q;

    logic signed [31:0] dir_sel, org_sel, s_sel;
    logic signed [32:0] u_sel, w_sel;
    logic signed [50:0] dv_sel;
    logic signed [35:0] px_val;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign uop      = uop_rom(pc_reg);

    // operands of the current pass share one axis
    always_comb
    begin
        unique case (uop.axis)
            2'd1:
            begin
                dir_sel = dir_reg[1]; org_sel = org_reg[1]; s_sel = s_reg[1];
                u_sel = u_reg[1]; w_sel = w_reg[1]; dv_sel = dv_reg[1];
            end
            2'd2:
            begin
                dir_sel = dir_reg[2]; org_sel = org_reg[2]; s_sel = s_reg[2];
                u_sel = u_reg[2]; w_sel = w_reg[2]; dv_sel = dv_reg[2];
            end
            default:
            begin
                dir_sel = dir_reg[0]; org_sel = org_reg[0]; s_sel = s_reg[0];
                u_sel = u_reg[0]; w_sel = w_reg[0]; dv_sel = dv_reg[0];
            end
        endcase
    end

    function automatic wide_t pick(input logic [3:0] src);
        wide_t v;
        unique case (src)
            SRC_DIR: v = wide_t'(dir_sel);
            SRC_U:   v = wide_t'(u_sel);
            SRC_W:   v = wide_t'(w_sel);
            SRC_DV:  v = wide_t'(dv_sel);
            SRC_A:   v = wide_t'(a_reg);
            SRC_B:   v = wide_t'(b_reg);
            SRC_C:   v = wide_t'(c_reg);
            SRC_D:   v = wide_t'(d_reg);
            SRC_E:   v = wide_t'(e_reg);
            SRC_ST:  v = wide_t'(st_reg);
            SRC_RT:  v = wide_t'(rt_reg);
            SRC_TOL: v = wide_t'(tol_reg);
            default: v = '0;
        endcase
        return v;
    endfunction

    // operand select follows the registers the function reads, not just src
    always_comb
    begin
        op_a = pick(uop.src_a);
        op_b = pick(uop.src_b);
    end

    assign mac_ctl.start = (state_reg == ST_MAC) && go_reg;
    assign mac_ctl.clr   = uop.clr;
    assign mac_ctl.sub   = uop.sub;
    assign div_ctl.start = (state_reg == ST_DIV) && go_reg;
    assign div_ctl.long_q = div_rt_reg;

    rsp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    rsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (cn_reg),
        .den   (cd_reg),
        .q     (div_q),
        .done  (div_done)
    );

    // n = b*st - d * 2^16, product scaled back by floor
    assign n_val   = mac_acc - (wide_t'(d_reg) <<< FRAC_BITS);
    assign shifted = mac_acc >>> FRAC_BITS;
    assign px_val  = 36'(wide_t'(s_sel) + shifted);

    always_comb
    begin
        state_next    = state_reg;
        go_next       = 1'b0;
        pc_next       = pc_reg;
        ret_next      = ret_reg;
        div_rt_next   = div_rt_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg; e_next = e_reg;
        cn_next       = cn_reg;
        cd_next       = cd_reg;
        rt_next       = rt_reg;
        st_next       = st_reg;
        tsq_next      = tsq_reg;
        rtmp_next     = rtmp_reg;
        px_next       = px_reg;
        dv_next       = dv_reg;
        dist_next     = dist_reg;
        seg_next      = seg_reg;
        best_rt_next  = best_rt_reg;
        best_idx_next = best_idx_reg;
        any_next      = any_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load      = 1'b0;
        hit_next      = 1'b0;
        newb_next     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_MAC;
                    pc_next    = PC_START;
                    go_next    = 1'b1;
                end
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    go_next = 1'b1;
                    pc_next = pc_reg + 5'd1;
                    unique case (uop.sto)
                        STO_A: a_next = dot_t'(mac_acc);
                        STO_B: b_next = dot_t'(mac_acc);
                        STO_C: c_next = dot_t'(mac_acc);
                        STO_D: d_next = dot_t'(mac_acc);
                        STO_E: e_next = dot_t'(mac_acc);
                        STO_TSQ:
                        begin
                            tsq_next = mac_acc[61:0];
                            if (a_reg == '0)
                            begin
                                // degenerate ray: only the segment parameter moves
                                rt_next = '0;
                                if (c_reg != '0)
                                begin
                                    cn_next    = wide_t'(e_reg);
                                    cd_next    = wide_t'(c_reg);
                                    ret_next   = PC_POINTS;
                                    state_next = ST_CLAMP;
                                end
                                else
                                begin
                                    st_next = '0;
                                    pc_next = PC_POINTS;
                                end
                            end
                            else if (c_reg == '0)
                            begin
                                // point segment: project start on the ray
                                st_next = '0;
                                if (d_reg < 0)
                                begin
                                    cn_next     = (-wide_t'(d_reg)) <<< FRAC_BITS;
                                    cd_next     = wide_t'(a_reg);
                                    div_rt_next = 1'b1;
                                    ret_next    = PC_POINTS;
                                    state_next  = ST_DIV;
                                end
                                else
                                begin
                                    rt_next = '0;
                                    pc_next = PC_POINTS;
                                end
                            end
                            else
                            begin
                                pc_next = PC_DEN;
                            end
                        end
                        STO_DEN:
                        begin
                            if (mac_acc > 0)
                            begin
                                cd_next = mac_acc;
                            end
                            else
                            begin
                                // parallel: segment parameter starts at zero
                                st_next = '0;
                                pc_next = PC_N;
                            end
                        end
                        STO_NUM:
                        begin
                            cn_next    = mac_acc;
                            ret_next   = PC_N;
                            state_next = ST_CLAMP;
                        end
                        STO_N:
                        begin
                            if (n_val < 0)
                            begin
                                // behind the origin: clamp ray, reproject
                                rt_next    = '0;
                                cn_next    = wide_t'(e_reg);
                                cd_next    = wide_t'(c_reg);
                                ret_next   = PC_POINTS;
                                state_next = ST_CLAMP;
                            end
                            else
                            begin
                                cn_next     = n_val;
                                cd_next     = wide_t'(a_reg);
                                div_rt_next = 1'b1;
                                ret_next    = PC_POINTS;
                                state_next  = ST_DIV;
                            end
                        end
                        STO_RX:
                        begin
                            rtmp_next = 50'(wide_t'(org_sel) + shifted);
                        end
                        STO_PX:
                        begin
                            unique case (uop.axis)
                                2'd1:
                                begin
                                    px_next[1] = px_val;
                                    dv_next[1] = 51'(rtmp_reg) - 51'(px_val);
                                end
                                2'd2:
                                begin
                                    px_next[2] = px_val;
                                    dv_next[2] = 51'(rtmp_reg) - 51'(px_val);
                                end
                                default:
                                begin
                                    px_next[0] = px_val;
                                    dv_next[0] = 51'(rtmp_reg) - 51'(px_val);
                                end
                            endcase
                        end
                        STO_DSQ:
                        begin
                            go_next    = 1'b0;
                            dist_next  = (mac_acc[WIDE_W-1:63] == '0) ? mac_acc[62:0]
                                                                       : {63{1'b1}};
                            state_next = ST_FIN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLAMP:
            begin
                if (cn_reg <= 0)
                begin
                    st_next    = '0;
                    state_next = ST_MAC;
                    pc_next    = ret_reg;
                    go_next    = 1'b1;
                end
                else if (cn_reg >= cd_reg)
                begin
                    st_next    = 17'(1 << FRAC_BITS);
                    state_next = ST_MAC;
                    pc_next    = ret_reg;
                    go_next    = 1'b1;
                end
                else
                begin
                    cn_next     = cn_reg <<< FRAC_BITS;
                    div_rt_next = 1'b0;
                    state_next  = ST_DIV;
                    go_next     = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_rt_reg)
                    begin
                        rt_next = div_q;
                    end
                    else
                    begin
                        st_next = div_q[16:0];
                    end
                    state_next = ST_MAC;
                    pc_next    = ret_reg;
                    go_next    = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    hit_next       = (dist_reg <= 63'(tsq_reg));
                    newb_next      = hit_next && (!any_reg || (rt_reg < best_rt_reg));
                    if (newb_next)
                    begin
                        best_rt_next  = rt_reg;
                        best_idx_next = seg_reg;
                        any_next      = 1'b1;
                    end
                    seg_next   = seg_reg + 16'd1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, configuration and pick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            org_reg[0]    <= '0;
            org_reg[1]    <= '0;
            org_reg[2]    <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= 32'sd65536;
            tol_reg       <= '0;
            seg_reg       <= '0;
            best_rt_reg   <= {31{1'b1}};
            best_idx_reg  <= '0;
            any_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            if (out_load && last_reg)
            begin
                seg_reg      <= '0;
                best_rt_reg  <= {31{1'b1}};
                best_idx_reg <= '0;
                any_reg      <= 1'b0;
            end
            else
            begin
                seg_reg      <= seg_next;
                best_rt_reg  <= best_rt_next;
                best_idx_reg <= best_idx_next;
                any_reg      <= any_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X: org_reg[0] <= cfg_data;
                    CFG_ORIGIN_Y: org_reg[1] <= cfg_data;
                    CFG_ORIGIN_Z: org_reg[2] <= cfg_data;
                    CFG_DIR_X:    dir_reg[0] <= cfg_data;
                    CFG_DIR_Y:    dir_reg[1] <= cfg_data;
                    CFG_DIR_Z:    dir_reg[2] <= cfg_data;
                    CFG_TOL:      tol_reg    <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath and output word
    always_ff @(posedge clk)
    begin
        pc_reg     <= pc_next;
        ret_reg    <= ret_next;
        div_rt_reg <= div_rt_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next;
        d_reg <= d_next; e_reg <= e_next;
        cn_reg     <= cn_next;
        cd_reg     <= cd_next;
        rt_reg     <= rt_next;
        st_reg     <= st_next;
        tsq_reg    <= tsq_next;
        rtmp_reg   <= rtmp_next;
        px_reg     <= px_next;
        dv_reg     <= dv_next;
        dist_reg   <= dist_next;
        if (in_take)
        begin
            s_reg[0] <= start_x;
            s_reg[1] <= start_y;
            s_reg[2] <= start_z;
            u_reg[0] <= 33'(end_x) - 33'(start_x);
            u_reg[1] <= 33'(end_y) - 33'(start_y);
            u_reg[2] <= 33'(end_z) - 33'(start_z);
            w_reg[0] <= 33'(org_reg[0]) - 33'(start_x);
            w_reg[1] <= 33'(org_reg[1]) - 33'(start_y);
            w_reg[2] <= 33'(org_reg[2]) - 33'(start_z);
            last_reg <= last;
        end
        if (out_load)
        begin
            hit_reg   <= hit_next;
            newb_reg  <= newb_next;
            segn_reg  <= seg_reg;
            rtp_reg   <= rt_reg;
            stp_reg   <= st_reg;
            dsq_reg   <= dist_reg;
            pt_reg[0] <= px_reg[0][31:0];
            pt_reg[1] <= px_reg[1][31:0];
            pt_reg[2] <= px_reg[2][31:0];
            bf_reg    <= any_next;
            bn_reg    <= best_idx_next;
            fin_reg   <= last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign new_best       = newb_reg;
    assign segment_number = segn_reg;
    assign ray_param      = rtp_reg;
    assign segment_param  = stp_reg;
    assign distance_sq    = dsq_reg;
    assign point_x        = pt_reg[0];
    assign point_y        = pt_reg[1];
    assign point_z        = pt_reg[2];
    assign best_found     = bf_reg;
    assign best_number    = bn_reg;
    assign final_res      = fin_reg;

endmodule
